>>> sv/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and defaults for the Pythagorean triple enumerator: default
// sizes, datapath operation codes and the command/status structs between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  // Default sizes
  localparam int unsigned PTP_SIDE_WIDTH  = 16;
  localparam int unsigned PTP_MAX_TRIPLES = 64;

  // Dividend/divisor selection for the shared divider
  typedef enum logic {
    DIV_ROW  = 1'b0,  // perimeter / 2m
    DIV_PAIR = 1'b1   // row quotient / (m+n)
  } div_sel_e;

  // Operations of the shared multiplier, issued in this order
  typedef enum logic [2:0] {
    MUL_MM = 3'd0,  // m*m
    MUL_NN = 3'd1,  // n*n
    MUL_MN = 3'd2,  // m*n
    MUL_A  = 3'd3,  // k*(m*m - n*n)
    MUL_B  = 3'd4,  // k*(2*m*n)
    MUL_C  = 3'd5   // k*(m*m + n*n)
  } mul_op_e;

  // Controller to datapath
  typedef struct packed {
    logic     load_p;     // capture perimeter, start root search
    logic     sqrt_step;  // one root bit
    logic     div_start;  // load divider operands
    div_sel_e div_sel;
    logic     div_step;   // one quotient bit
    logic     q_load;     // keep row quotient
    logic     gcd_start;
    logic     gcd_step;
    logic     n_inc;
    logic     m_inc;      // next row, n back to 1
    logic     mul_en;
    mul_op_e  mul_op;
    logic     pend_load;  // new triple into the pending slot
    logic     out_load;   // fill the output register
    logic     out_empty;  // output the not-found item
    logic     out_last;
    logic     out_ovf;
  } ptp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sqrt_last;
    logic limit_lt2;
    logic m_at_limit;
    logic n_at_end;
    logic pair_odd;
    logic div_last;
    logic div_rem_zero;
    logic gcd_done;
    logic gcd_one;
    logic out_free;
  } ptp_stat_t;

endpackage

`default_nettype wire

>>> sv/ptp_ctrl.sv
// ----------------------------------------------------------------------------
// ptp_ctrl
// Sequencer for the enumeration: root search, row and pair loops, the
// coprimality and divisibility checks, side computation and the hand-off of
// results through a one-deep pending slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_ctrl import ptp_pkg::*; #(
  parameter int unsigned MAX_TRIPLES = PTP_MAX_TRIPLES
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ptp_stat_t stat_i,
  output ptp_cmd_t       cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_TRIPLES + 1);

  typedef enum logic [14:0] {
    ST_IDLE      = 15'h0001,
    ST_SQRT      = 15'h0002,
    ST_ROW_START = 15'h0004,
    ST_ROW_DIV   = 15'h0008,
    ST_ROW_CHK   = 15'h0010,
    ST_PAIR_CHK  = 15'h0020,
    ST_GCD       = 15'h0040,
    ST_PAIR_DIV  = 15'h0080,
    ST_PAIR_EVAL = 15'h0100,
    ST_MUL       = 15'h0200,
    ST_PUSH      = 15'h0400,
    ST_NEXT_PAIR = 15'h0800,
    ST_NEXT_ROW  = 15'h1000,
    ST_FINISH    = 15'h2000,
    ST_OVF       = 15'h4000
  } ctl_state_e;

  ctl_state_e          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  mul_op_e             mul_op_q, mul_op_d;
  logic                has_pend;
  logic                at_max;

  // count covers the pending triple as well as those already sent
  assign has_pend = (count_q != '0);
  assign at_max   = (count_q == CntW'(MAX_TRIPLES));

  // Next state and commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    state_d    = state_q;
    count_d    = count_q;
    mul_op_d   = mul_op_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_p = 1'b1;
          count_d      = '0;
          state_d      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_last) begin
          state_d = ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        if (stat_i.limit_lt2) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_ROW;
          state_d         = ST_ROW_DIV;
        end
      end
      ST_ROW_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_ROW_CHK;
        end
      end
      ST_ROW_CHK: begin
        // rows where 2m does not divide the perimeter hold no triple
        cmd_o.q_load = 1'b1;
        state_d      = stat_i.div_rem_zero ? ST_PAIR_CHK : ST_NEXT_ROW;
      end
      ST_PAIR_CHK: begin
        if (stat_i.pair_odd) begin
          cmd_o.gcd_start = 1'b1;
          state_d         = ST_GCD;
        end else begin
          state_d = ST_NEXT_PAIR;
        end
      end
      ST_GCD: begin
        if (stat_i.gcd_done) begin
          if (stat_i.gcd_one) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_PAIR;
            state_d         = ST_PAIR_DIV;
          end else begin
            state_d = ST_NEXT_PAIR;
          end
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_PAIR_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_PAIR_EVAL;
        end
      end
      ST_PAIR_EVAL: begin
        if (!stat_i.div_rem_zero) begin
          state_d = ST_NEXT_PAIR;
        end else if (at_max) begin
          state_d = ST_OVF;
        end else begin
          mul_op_d = MUL_MM;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = mul_op_q;
        case (mul_op_q)
          MUL_MM:  mul_op_d = MUL_NN;
          MUL_NN:  mul_op_d = MUL_MN;
          MUL_MN:  mul_op_d = MUL_A;
          MUL_A:   mul_op_d = MUL_B;
          MUL_B:   mul_op_d = MUL_C;
          default: state_d  = ST_PUSH;
        endcase
      end
      ST_PUSH: begin
        // the older triple leaves only once a newer one proves it is not last
        if (!has_pend) begin
          cmd_o.pend_load = 1'b1;
          count_d         = count_q + CntW'(1);
          state_d         = ST_NEXT_PAIR;
        end else if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.pend_load = 1'b1;
          count_d         = count_q + CntW'(1);
          state_d         = ST_NEXT_PAIR;
        end
      end
      ST_NEXT_PAIR: begin
        if (stat_i.n_at_end) begin
          state_d = ST_NEXT_ROW;
        end else begin
          cmd_o.n_inc = 1'b1;
          state_d     = ST_PAIR_CHK;
        end
      end
      ST_NEXT_ROW: begin
        if (stat_i.m_at_limit) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.m_inc = 1'b1;
          state_d     = ST_ROW_START;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = !has_pend;
          cmd_o.out_last  = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_ovf  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      mul_op_q <= MUL_MM;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      mul_op_q <= mul_op_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/ptp_datapath.sv
// ----------------------------------------------------------------------------
// ptp_datapath
// Datapath of the enumerator: bit-serial integer square root, restoring
// divider, binary GCD, shared multiplier, pending triple and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_datapath import ptp_pkg::*; #(
  parameter int unsigned SIDE_WIDTH = PTP_SIDE_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SIDE_WIDTH-1:0] perimeter_i,
  input  wire ptp_cmd_t              cmd_i,
  output ptp_stat_t                  stat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SIDE_WIDTH-1:0]      side_short_o,
  output logic [SIDE_WIDTH-1:0]      side_middle_o,
  output logic [SIDE_WIDTH-1:0]      side_long_o,
  output logic                       found_o,
  output logic                       overflow_o,
  output logic                       last_o
);

  localparam int unsigned SW  = SIDE_WIDTH;
  localparam int unsigned MW  = (SIDE_WIDTH + 1) / 2;  // holds m, n and the root
  localparam int unsigned DVW = MW + 1;                // divisor: 2m or m+n
  localparam int unsigned CW  = $clog2(SIDE_WIDTH);

  logic [SW-1:0]     p_q;
  logic [MW-1:0]     root_q, sbit_q, trial;
  logic [2*MW-1:0]   trial_sq, half_p;
  logic              root_fits;
  logic [MW-1:0]     m_q, n_q;
  logic [SW-1:0]     q_q;
  logic [DVW-1:0]    div_dsr_q, div_rem_q;
  logic [SW-1:0]     div_quo_q;
  logic [CW-1:0]     div_cnt_q;
  logic [DVW:0]      div_shift, div_diff;
  logic              div_ge;
  logic [MW-1:0]     ga_q, gb_q;
  logic [SW-1:0]     mul_x, mul_y;
  logic [2*SW-1:0]   mul_full;
  logic [SW-1:0]     mm_q, nn_q, mn_q, sa_q, sb_q, sc_q;
  logic [SW-1:0]     pend_short_q, pend_middle_q, pend_long_q;
  logic              out_valid_q;
  logic [SW-1:0]     out_short_q, out_middle_q, out_long_q;
  logic              out_found_q, out_ovf_q, out_last_q;
  logic              out_free;

  // Root search: one bit per cycle, trial square against floor(p/2)
  assign trial     = root_q | sbit_q;
  assign trial_sq  = (2 * MW)'(trial) * (2 * MW)'(trial);
  assign half_p    = (2 * MW)'(p_q >> 1);
  assign root_fits = (trial_sq <= half_p);

  // Restoring divider step
  assign div_shift = {div_rem_q, div_quo_q[SW-1]};
  assign div_ge    = (div_shift >= {1'b0, div_dsr_q});
  assign div_diff  = div_shift - {1'b0, div_dsr_q};

  // Multiplier operands; only the low side-width bits are kept
  always_comb begin
    case (cmd_i.mul_op)
      MUL_MM: begin
        mul_x = SW'(m_q);
        mul_y = SW'(m_q);
      end
      MUL_NN: begin
        mul_x = SW'(n_q);
        mul_y = SW'(n_q);
      end
      MUL_MN: begin
        mul_x = SW'(m_q);
        mul_y = SW'(n_q);
      end
      MUL_A: begin
        mul_x = div_quo_q;
        mul_y = mm_q - nn_q;
      end
      MUL_B: begin
        mul_x = div_quo_q;
        mul_y = {mn_q[SW-2:0], 1'b0};
      end
      MUL_C: begin
        mul_x = div_quo_q;
        mul_y = mm_q + nn_q;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign mul_full = (2 * SW)'(mul_x) * (2 * SW)'(mul_y);

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_p) begin
      p_q    <= perimeter_i;
      root_q <= '0;
      sbit_q <= {1'b1, {(MW-1){1'b0}}};
      m_q    <= MW'(2);
      n_q    <= MW'(1);
    end else begin
      if (cmd_i.sqrt_step) begin
        if (root_fits) begin
          root_q <= trial;
        end
        sbit_q <= sbit_q >> 1;
      end
      if (cmd_i.m_inc) begin
        m_q <= m_q + MW'(1);
        n_q <= MW'(1);
      end else if (cmd_i.n_inc) begin
        n_q <= n_q + MW'(1);
      end
    end

    // divider
    if (cmd_i.div_start) begin
      if (cmd_i.div_sel == DIV_ROW) begin
        div_dsr_q <= {m_q, 1'b0};
        div_quo_q <= p_q;
      end else begin
        div_dsr_q <= {1'b0, m_q} + {1'b0, n_q};
        div_quo_q <= q_q;
      end
      div_rem_q <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? div_diff[DVW-1:0] : div_shift[DVW-1:0];
      div_quo_q <= {div_quo_q[SW-2:0], div_ge};
      div_cnt_q <= div_cnt_q + CW'(1);
    end
    if (cmd_i.q_load) begin
      q_q <= div_quo_q;
    end

    // binary GCD; one operand is odd, so factors of two are dropped freely
    if (cmd_i.gcd_start) begin
      ga_q <= m_q;
      gb_q <= n_q;
    end else if (cmd_i.gcd_step) begin
      if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q > gb_q) begin
        ga_q <= ga_q - gb_q;
      end else begin
        gb_q <= gb_q - ga_q;
      end
    end

    // multiplier results
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        MUL_MM:  mm_q <= mul_full[SW-1:0];
        MUL_NN:  nn_q <= mul_full[SW-1:0];
        MUL_MN:  mn_q <= mul_full[SW-1:0];
        MUL_A:   sa_q <= mul_full[SW-1:0];
        MUL_B:   sb_q <= mul_full[SW-1:0];
        MUL_C:   sc_q <= mul_full[SW-1:0];
        default: sc_q <= sc_q;
      endcase
    end

    // pending triple, legs sorted
    if (cmd_i.pend_load) begin
      pend_short_q  <= (sb_q < sa_q) ? sb_q : sa_q;
      pend_middle_q <= (sb_q < sa_q) ? sa_q : sb_q;
      pend_long_q   <= sc_q;
    end

    // output payload
    if (cmd_i.out_load) begin
      out_short_q  <= cmd_i.out_empty ? '0 : pend_short_q;
      out_middle_q <= cmd_i.out_empty ? '0 : pend_middle_q;
      out_long_q   <= cmd_i.out_empty ? '0 : pend_long_q;
      out_found_q  <= !cmd_i.out_empty;
      out_ovf_q    <= cmd_i.out_ovf;
      out_last_q   <= cmd_i.out_last;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Status
  assign stat_o.sqrt_last    = sbit_q[0];
  assign stat_o.limit_lt2    = (root_q < MW'(2));
  assign stat_o.m_at_limit   = (m_q == root_q);
  assign stat_o.n_at_end     = (n_q == (m_q - MW'(1)));
  assign stat_o.pair_odd     = m_q[0] ^ n_q[0];
  assign stat_o.div_last     = (div_cnt_q == CW'(SW - 1));
  assign stat_o.div_rem_zero = (div_rem_q == '0);
  assign stat_o.gcd_done     = (ga_q == gb_q);
  assign stat_o.gcd_one      = (ga_q == MW'(1));
  assign stat_o.out_free     = out_free;

  assign out_valid_o   = out_valid_q;
  assign side_short_o  = out_short_q;
  assign side_middle_o = out_middle_q;
  assign side_long_o   = out_long_q;
  assign found_o       = out_found_q;
  assign overflow_o    = out_ovf_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

>>> sv/pythagorean_triples_by_perimeter.sv
// Steps: a bit-serial root search, then per row m a division by 2m; rows where
// 2m divides the perimeter add per odd pair a GCD, for a coprime pair a
// division by m+n and, for a hit, the six products and the push.
// One perimeter at a time: a new item is taken once the final result sits in
// the output register.
// Reset is asynchronous; it clears the controller and output valid only.
// ----------------------------------------------------------------------------
// pythagorean_triples_by_perimeter
// Lists every integer right triangle of a given perimeter via Euclid's
// generator pairs, in order of m then n, with last and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pythagorean_triples_by_perimeter import ptp_pkg::*; #(
  parameter int unsigned SIDE_WIDTH  = PTP_SIDE_WIDTH,
  parameter int unsigned MAX_TRIPLES = PTP_MAX_TRIPLES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SIDE_WIDTH-1:0] perimeter_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SIDE_WIDTH-1:0]      side_short_o,
  output logic [SIDE_WIDTH-1:0]      side_middle_o,
  output logic [SIDE_WIDTH-1:0]      side_long_o,
  output logic                       found_o,
  output logic                       overflow_o,
  output logic                       last_o
);

  ptp_cmd_t  cmd;
  ptp_stat_t stat;

  // Sequencer
  ptp_ctrl #(
    .MAX_TRIPLES(MAX_TRIPLES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Arithmetic and result registers
  ptp_datapath #(
    .SIDE_WIDTH(SIDE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .perimeter_i  (perimeter_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .side_short_o (side_short_o),
    .side_middle_o(side_middle_o),
    .side_long_o  (side_long_o),
    .found_o      (found_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while enumeration runs");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (last_o && !overflow_o))
    else $error("not-found item without last");

  a_overflow_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> last_o)
    else $error("overflow on a non-final item");

  a_sides_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |->
      ((side_short_o < side_middle_o) && (side_middle_o < side_long_o)))
    else $error("triple sides out of order");

endmodule

`default_nettype wire
